@@ src/magic_framed_utf16_deframer_assert.svh @@
// Assertion macros shared by the deframer RTL.
// Expects signals named clock and reset in the module that uses them.
`ifndef MAGIC_FRAMED_UTF16_DEFRAMER_ASSERT_SVH
`define MAGIC_FRAMED_UTF16_DEFRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFUD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MFUD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

@@ src/mfud_pkg.sv @@
// Shared types and constants for the framed UTF-16 deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mfud_pkg;

   localparam int unsigned DEF_SIZE_LIMIT = 1048576;

   localparam logic [31:0] MAGIC_FIRST_RESET  = 32'h1234ABCD;
   localparam logic [31:0] MAGIC_SECOND_RESET = 32'hABCD1234;

   localparam logic [31:0] HEADER_BYTES = 32'd16;
   localparam logic [31:0] MIN_FULL_SIZE = 32'd18;

   // Byte positions within the header at which a word is complete.
   localparam logic [3:0] POS_SIZE_END    = 4'd3;
   localparam logic [3:0] POS_MAGIC1_END  = 4'd7;
   localparam logic [3:0] POS_MAGIC2_END  = 4'd11;
   localparam logic [3:0] POS_HEADER_END  = 4'd15;

   // Configuration register indices.
   localparam logic [1:0] CSR_MAGIC_FIRST  = 2'd0;
   localparam logic [1:0] CSR_MAGIC_SECOND = 2'd1;
   localparam logic [1:0] CSR_MAX_SIZE     = 2'd2;

   // Result kinds.
   localparam logic [2:0] KIND_UNIT       = 3'd0;
   localparam logic [2:0] KIND_DONE       = 3'd1;
   localparam logic [2:0] KIND_BAD_MAGIC  = 3'd2;
   localparam logic [2:0] KIND_SIZE_UNDER = 3'd3;
   localparam logic [2:0] KIND_SIZE_OVER  = 3'd4;
   localparam logic [2:0] KIND_NO_TERM    = 3'd5;
   localparam logic [2:0] KIND_ODD        = 3'd6;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] unit;
      logic [20:0] length;
   } result_type;

endpackage

`default_nettype wire

@@ src/magic_framed_utf16_deframer.sv @@
// Top level of the framed UTF-16 deframer: input register, parser, result register.
// Depends on mfud_pkg, mfud_csr, mfud_parse and the assertion macro header.
`default_nettype none

`include "magic_framed_utf16_deframer_assert.svh"

// Usage
// The request channel carries one message byte per word (req_valid, req_stall,
// req_data_byte). Each message starts with a 16-byte header: a little-endian
// size, two magic words and a reserved word. Payload bytes pair into UTF-16LE
// code units. The response channel (rsp_valid, rsp_stall, rsp_kind, rsp_unit,
// rsp_length) carries at most one word per request word: a payload unit, a
// completion with the message size, or an error code that ends the message.
// The configuration port writes the two magic words and the size limit; it must
// be written only while the block is idle; the block itself does not enforce this.
// A byte accepted on the request channel waits in the input register while the
// parser works on it, and its result is loaded into the result register when the
// byte is consumed, so the receiver can take it from there.
// Throughput is one byte per cycle while no stall holds a byte, set by the parser state update.
// When the receiver stalls and a result is waiting, bytes that produce no result
// still flow through; a byte that does produce one waits in the input register
// and req_stall is raised until the result register is taken.
// A synchronous reset empties both registers, restarts header parsing and
// restores the default magic words and size limit.

module magic_framed_utf16_deframer
   import mfud_pkg::*;
#(
   parameter int unsigned SIZE_LIMIT = DEF_SIZE_LIMIT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [15:0]      rsp_unit,
   output logic [20:0]      rsp_length,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   result_type  rsp_ff;
   logic [31:0] magic_first;
   logic [31:0] magic_second;
   logic [20:0] limit;
   logic        emit_valid;
   result_type  emit_result;
   logic        out_free;
   logic        fire;
   logic        req_take;

   mfud_csr #(
      .SIZE_LIMIT(SIZE_LIMIT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .magic_first (magic_first),
      .magic_second(magic_second),
      .limit       (limit)
   );

   mfud_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .advance     (fire),
      .data_byte   (in_byte_ff),
      .magic_first (magic_first),
      .magic_second(magic_second),
      .limit       (limit),
      .emit_valid  (emit_valid),
      .emit_result (emit_result)
   );

   // The held byte is consumed when it produces nothing, or when the result
   // register is empty or being emptied this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && (out_free || !emit_valid);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire && emit_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
      end
      if (fire && emit_valid) begin
         rsp_ff <= emit_result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = rsp_ff.kind;
   assign rsp_unit   = rsp_ff.unit;
   assign rsp_length = rsp_ff.length;

   // A byte that cannot be consumed must stay put in the input register.
   `MFUD_ASSERT_NEXT(a_hold_input, in_valid_ff && !fire, in_valid_ff && $stable(in_byte_ff))
   // Only payload units carry a unit value.
   `MFUD_ASSERT_SAME(a_unit_only, rsp_valid_ff && rsp_ff.kind != KIND_UNIT, rsp_ff.unit == '0)
   // Only completions carry a length, and a completion is never shorter than
   // a header plus a terminator.
   `MFUD_ASSERT_SAME(a_length_done, rsp_valid_ff && rsp_ff.kind == KIND_DONE, rsp_ff.length >= 21'd18)

endmodule

`default_nettype wire

@@ src/mfud_csr.sv @@
// Configuration registers of the deframer: magic words and the size limit.
// Depends on mfud_pkg.
`default_nettype none

module mfud_csr
   import mfud_pkg::*;
#(
   parameter int unsigned SIZE_LIMIT = DEF_SIZE_LIMIT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output logic [31:0]      magic_first,
   output logic [31:0]      magic_second,
   output logic [20:0]      limit
);

   localparam logic [20:0] LIMIT_CAP = 21'(SIZE_LIMIT);

   logic [31:0] magic_first_ff;
   logic [31:0] magic_second_ff;
   logic [20:0] limit_ff;
   logic [20:0] limit_in;

   // The written size limit is saturated here, so the parser sees the
   // effective limit directly.
   always_comb begin
      if (csr_wdata[20:0] > LIMIT_CAP) begin
         limit_in = LIMIT_CAP;
      end else begin
         limit_in = csr_wdata[20:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff  <= MAGIC_FIRST_RESET;
         magic_second_ff <= MAGIC_SECOND_RESET;
         limit_ff        <= LIMIT_CAP;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAGIC_FIRST:  magic_first_ff  <= csr_wdata;
            CSR_MAGIC_SECOND: magic_second_ff <= csr_wdata;
            CSR_MAX_SIZE:     limit_ff        <= limit_in;
            default: ;
         endcase
      end
   end

   assign magic_first  = magic_first_ff;
   assign magic_second = magic_second_ff;
   assign limit        = limit_ff;

endmodule

`default_nettype wire

@@ src/mfud_parse.sv @@
// Frame parser: header gathering, header checks and payload unit assembly.
// Depends on mfud_pkg; one word is consumed per cycle in which advance is high.
`default_nettype none

module mfud_parse
   import mfud_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic [7:0]  data_byte,
   input  wire logic [31:0] magic_first,
   input  wire logic [31:0] magic_second,
   input  wire logic [20:0] limit,
   output logic             emit_valid,
   output result_type       emit_result
);

   logic [20:0] pos_ff;
   logic [20:0] pos_in;
   logic [31:0] size_ff;
   logic [31:0] size_in;
   logic [31:0] gather_ff;
   logic [31:0] gather_in;
   logic        magic_ok_ff;
   logic        magic_ok_in;
   logic [7:0]  held_ff;
   logic [7:0]  held_in;
   logic [31:0] gather_next;
   logic [31:0] pos_ext;
   logic [15:0] last_unit;
   logic        restart;

   always_comb begin
      gather_next = {data_byte, gather_ff[31:8]};
      pos_ext     = {11'd0, pos_ff};
      last_unit   = {data_byte, held_ff};
      pos_in      = pos_ff + 21'd1;
      size_in     = size_ff;
      gather_in   = gather_ff;
      magic_ok_in = magic_ok_ff;
      held_in     = held_ff;
      restart     = 1'b0;
      emit_valid  = 1'b0;
      emit_result = '0;

      if (pos_ext < HEADER_BYTES) begin
         gather_in = gather_next;
         case (pos_ff[3:0])
            POS_SIZE_END: begin
               size_in = gather_next;
            end
            POS_MAGIC1_END: begin
               magic_ok_in = (gather_next == magic_first);
            end
            POS_MAGIC2_END: begin
               if (!magic_ok_ff || gather_next != magic_second) begin
                  emit_valid       = 1'b1;
                  emit_result.kind = KIND_BAD_MAGIC;
               end else if (size_ff < HEADER_BYTES) begin
                  emit_valid       = 1'b1;
                  emit_result.kind = KIND_SIZE_UNDER;
               end else if (size_ff > {11'd0, limit}) begin
                  emit_valid       = 1'b1;
                  emit_result.kind = KIND_SIZE_OVER;
               end
            end
            POS_HEADER_END: begin
               if (size_ff == HEADER_BYTES) begin
                  emit_valid       = 1'b1;
                  emit_result.kind = KIND_NO_TERM;
               end
            end
            default: ;
         endcase
         restart = emit_valid;
      end else if (pos_ext + 32'd1 >= size_ff) begin
         // Final byte of the message: report the outcome of the whole frame.
         restart    = 1'b1;
         emit_valid = 1'b1;
         if (size_ff < MIN_FULL_SIZE) begin
            emit_result.kind = KIND_NO_TERM;
         end else if (size_ff[0]) begin
            emit_result.kind = KIND_ODD;
         end else if (last_unit != 16'd0) begin
            emit_result.kind = KIND_NO_TERM;
         end else begin
            emit_result.kind   = KIND_DONE;
            emit_result.length = size_ff[20:0];
         end
      end else if (!pos_ff[0]) begin
         held_in = data_byte;
      end else begin
         emit_valid       = 1'b1;
         emit_result.kind = KIND_UNIT;
         emit_result.unit = last_unit;
      end

      if (restart) begin
         pos_in      = '0;
         size_in     = '0;
         gather_in   = '0;
         magic_ok_in = 1'b0;
         held_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         size_ff     <= '0;
         gather_ff   <= '0;
         magic_ok_ff <= 1'b0;
         held_ff     <= '0;
      end else if (advance) begin
         pos_ff      <= pos_in;
         size_ff     <= size_in;
         gather_ff   <= gather_in;
         magic_ok_ff <= magic_ok_in;
         held_ff     <= held_in;
      end
   end

endmodule

`default_nettype wire
